// ===== design/hbc_pkg.sv =====
`default_nettype none

package hbc_pkg;

   localparam int BLOCK_BITS = 32;
   localparam int STAMP_BITS = 32;
   localparam int COUNT_BITS = 8;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
   localparam logic [STAMP_BITS-1:0] STAMP_NONE = '1;

   localparam logic [1:0] FUNC_GET     = 2'd0;
   localparam logic [1:0] FUNC_RELEASE = 2'd1;
   localparam logic [1:0] FUNC_PIN     = 2'd2;
   localparam logic [1:0] FUNC_UNPIN   = 2'd3;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_MISS   = 2'd1;
   localparam logic [1:0] STATUS_NOFREE = 2'd2;
   localparam logic [1:0] STATUS_UNDER  = 2'd3;

   typedef struct packed {
      logic [1:0]            func;
      logic [7:0]            dev;
      logic [BLOCK_BITS-1:0] block_number;
      logic [2:0]            bucket;
      logic [4:0]            way;
      logic [STAMP_BITS-1:0] time_now;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [2:0] set_index;
      logic [4:0] entry_way;
      logic       needs_fill;
   } rsp_type;

   typedef struct packed {
      logic [7:0]            dev;
      logic [BLOCK_BITS-1:0] blk;
      logic [COUNT_BITS-1:0] count;
      logic [STAMP_BITS-1:0] stamp;
      logic                  valid;
   } entry_type;

endpackage

`default_nettype wire

// ===== design/hbc_mod_unit.sv =====
`default_nettype none

module hbc_mod_unit #(
   parameter int BUCKETS = 7
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [hbc_pkg::BLOCK_BITS-1:0]      value,
   output logic                                     done,
   output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] remainder
);
   import hbc_pkg::*;

   localparam int SW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int LW    = $clog2(BUCKETS);
   localparam int SHIFT = BLOCK_BITS + LW;
   localparam int PW    = SHIFT + BLOCK_BITS;
   // floor(2^SHIFT / BUCKETS) + 1 yields the exact quotient for every block number
   localparam logic [63:0] RECIP = ((64'd1 << SHIFT) / 64'(BUCKETS)) + 64'd1;

   logic [BLOCK_BITS-1:0] value_ff;
   logic [PW-1:0]         prod_ff;
   logic [PW-1:0]         prod_in;
   logic [BLOCK_BITS-1:0] quot;
   logic [BLOCK_BITS-1:0] diff;
   logic [SW-1:0]         rem_ff;
   logic [SW-1:0]         rem_in;
   logic [1:0]            phase_ff;
   logic                  done_ff;

   // multiply by the reciprocal, then subtract quotient times BUCKETS from the value to get the remainder
   assign prod_in = PW'(value_ff) * PW'(RECIP);
   assign quot    = prod_ff[PW-1:SHIFT];
   assign diff    = value_ff - quot * BLOCK_BITS'(BUCKETS);
   assign rem_in  = diff[SW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= {phase_ff[0], start};
         done_ff  <= phase_ff[1];
      end
      if (start) begin
         value_ff <= value;
      end
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== design/hbc_tag_ram.sv =====
`default_nettype none

module hbc_tag_ram #(
   parameter int DEPTH = 224
) (
   input  wire logic                                    clock,
   input  wire logic                                    we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire hbc_pkg::entry_type                      wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output hbc_pkg::entry_type                           rdata
);
   import hbc_pkg::*;

   entry_type mem [DEPTH];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== design/hashed_block_cache_tag_store_unit.sv =====
// Tag store of a hashed block cache with release-time LRU replacement.
// Request channel (req_valid/req_stall/req_data) takes one beat per
// operation: get, release, pin or unpin. Response channel
// (rsp_valid/rsp_stall/rsp_data) returns exactly one beat per request,
// in request order.
// A get first reduces block_number modulo BUCKETS with a reciprocal
// multiply (value, product and remainder registered in turn), then walks
// the WAYS entries of its set out of the tag RAM, one read per cycle,
// looking for a match and the oldest free victim; the walk ends early on
// a hit. Release, pin and unpin read a single entry and write it back,
// unless the count would underflow or the handle is out of range.
// One operation is in flight at a time; the next request is taken as soon
// as the previous result sits in the response register.
// After reset the tag RAM is swept to zero, one entry per cycle, over
// all BUCKETS*WAYS entries (224 at the default size); req_stall stays
// high during the sweep.
// While rsp_stall is high the response beat holds; a finished operation
// then waits until the response register frees before completing.
`default_nettype none

module hashed_block_cache_tag_store_unit #(
   parameter int BUCKETS = 7,
   parameter int WAYS    = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire hbc_pkg::req_type req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output hbc_pkg::rsp_type rsp_data
);
   import hbc_pkg::*;

   localparam int ENTRIES = BUCKETS * WAYS;
   localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int SW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int IW      = $clog2(WAYS + 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_SCAN,
      ST_GET_WR,
      ST_H_CHK,
      ST_H_WR,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [SW-1:0] set_ff, set_in;
   logic [AW-1:0] base_ff, base_in;
   logic [IW-1:0] issue_ff, issue_in;
   logic          chk_ff, chk_in;
   logic [WW-1:0] chk_way_ff, chk_way_in;
   logic          hit_ff, hit_in;
   logic          found_ff, found_in;
   logic [WW-1:0] victim_ff, victim_in;
   logic [STAMP_BITS-1:0] best_ff, best_in;
   entry_type     entry_ff, entry_in;
   logic [AW-1:0] clr_ff, clr_in;
   rsp_type       result_ff, result_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   entry_type     mem_wdata;
   logic [AW-1:0] mem_raddr;
   entry_type     mem_rdata;

   logic          mod_start;
   logic          mod_done;
   logic [SW-1:0] mod_rem;

   logic [AW-1:0] handle_addr;
   logic          handle_ok;
   logic          out_free;
   logic          match;
   logic [SW+2:0] set_ext;
   logic [WW+4:0] victim_ext;

   assign mod_start = (state_ff == ST_IDLE) && req_valid && (req_data.func == FUNC_GET);

   hbc_mod_unit #(
      .BUCKETS (BUCKETS)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .value     (req_data.block_number),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   hbc_tag_ram #(
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign handle_addr = AW'(32'(req_ff.bucket) * WAYS + 32'(req_ff.way));
   assign handle_ok   = (32'(req_ff.bucket) < BUCKETS) && (32'(req_ff.way) < WAYS);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign match       = chk_ff && (mem_rdata.blk == req_ff.block_number)
                        && (mem_rdata.dev == req_ff.dev);
   assign set_ext     = {3'b000, set_ff};
   assign victim_ext  = {5'b00000, victim_ff};

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      set_in       = set_ff;
      base_in      = base_ff;
      issue_in     = issue_ff;
      chk_in       = chk_ff;
      chk_way_in   = chk_way_ff;
      hit_in       = hit_ff;
      found_in     = found_ff;
      victim_in    = victim_ff;
      best_in      = best_ff;
      entry_in     = entry_ff;
      clr_in       = clr_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = handle_addr;
      mem_wdata    = mem_rdata;
      mem_raddr    = handle_addr;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            if (clr_ff == AW'(ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = (req_data.func == FUNC_GET) ? ST_MOD : ST_H_CHK;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               set_in   = mod_rem;
               base_in  = AW'(32'(mod_rem) * WAYS);
               issue_in = '0;
               chk_in   = 1'b0;
               hit_in   = 1'b0;
               found_in = 1'b0;
               best_in  = STAMP_NONE;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // check the way read last cycle, issue the next read
            if (match) begin
               hit_in    = 1'b1;
               victim_in = chk_way_ff;
               entry_in  = mem_rdata;
               chk_in    = 1'b0;
               state_in  = ST_GET_WR;
            end else begin
               if (chk_ff && (mem_rdata.count == '0) && (mem_rdata.stamp < best_ff)) begin
                  best_in   = mem_rdata.stamp;
                  victim_in = chk_way_ff;
                  found_in  = 1'b1;
               end
               if (issue_ff < IW'(WAYS)) begin
                  mem_raddr  = base_ff + AW'(issue_ff);
                  chk_in     = 1'b1;
                  chk_way_in = WW'(issue_ff);
                  issue_in   = issue_ff + 1'b1;
               end else begin
                  chk_in   = 1'b0;
                  state_in = ST_GET_WR;
               end
            end
         end
         ST_GET_WR: begin
            mem_waddr            = base_ff + AW'(victim_ff);
            result_in.set_index  = set_ext[2:0];
            result_in.entry_way  = victim_ext[4:0];
            if (hit_ff) begin
               mem_we               = 1'b1;
               mem_wdata            = entry_ff;
               mem_wdata.valid      = 1'b1;
               if (entry_ff.count != COUNT_MAX) begin
                  mem_wdata.count = entry_ff.count + 1'b1;
               end
               result_in.status     = STATUS_OK;
               result_in.needs_fill = !entry_ff.valid;
            end else if (found_ff) begin
               mem_we               = 1'b1;
               mem_wdata.dev        = req_ff.dev;
               mem_wdata.blk        = req_ff.block_number;
               mem_wdata.count      = COUNT_BITS'(1);
               mem_wdata.stamp      = best_ff;
               mem_wdata.valid      = 1'b1;
               result_in.status     = STATUS_MISS;
               result_in.needs_fill = 1'b1;
            end else begin
               result_in.status     = STATUS_NOFREE;
               result_in.entry_way  = '0;
               result_in.needs_fill = 1'b0;
            end
            state_in = ST_DONE;
         end
         ST_H_CHK: begin
            result_in.status     = STATUS_OK;
            result_in.set_index  = req_ff.bucket;
            result_in.entry_way  = req_ff.way;
            result_in.needs_fill = 1'b0;
            // out-of-range handles complete without touching the store
            state_in = handle_ok ? ST_H_WR : ST_DONE;
         end
         ST_H_WR: begin
            mem_wdata = mem_rdata;
            if (req_ff.func == FUNC_PIN) begin
               mem_we = 1'b1;
               if (mem_rdata.count != COUNT_MAX) begin
                  mem_wdata.count = mem_rdata.count + 1'b1;
               end
            end else if (mem_rdata.count == '0) begin
               result_in.status = STATUS_UNDER;
            end else begin
               mem_we          = 1'b1;
               mem_wdata.count = mem_rdata.count - 1'b1;
               if ((req_ff.func == FUNC_RELEASE) && (mem_rdata.count == COUNT_BITS'(1))) begin
                  mem_wdata.stamp = req_ff.time_now;
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff     <= req_in;
      set_ff     <= set_in;
      base_ff    <= base_in;
      issue_ff   <= issue_in;
      chk_way_ff <= chk_way_in;
      hit_ff     <= hit_in;
      found_ff   <= found_in;
      victim_ff  <= victim_in;
      best_ff    <= best_in;
      entry_ff   <= entry_in;
      result_ff  <= result_in;
      rsp_ff     <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_we)
      else $error("tag RAM written while idle");

   a_miss_fills: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == STATUS_MISS)) |-> rsp_ff.needs_fill)
      else $error("allocated entry not marked for fill");

   a_nofree_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == STATUS_NOFREE))
      |-> ((rsp_ff.entry_way == '0) && !rsp_ff.needs_fill))
      else $error("no-free response carries an entry");

   a_reset_sweep: assert property (@(posedge clock)
      reset |=> (state_ff == ST_CLEAR))
      else $error("reset did not start the clearing sweep");

   a_mod_owner: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (state_ff == ST_MOD))
      else $error("remainder finished outside a get");

endmodule

`default_nettype wire
